FILE: sv/lsdu_pkg.sv
`timescale 1ns / 1ps

package lsdu_pkg;

    // Fraction bits of eta (Q8.24).
    localparam int IN_FRAC = 24;
    // Integer part width of eta * log2(e).
    localparam int EXP_INT_W = 33 - IN_FRAC;
    localparam int EXP_TERMS = 12;
    // Quotient bits of the reciprocal.
    localparam int RCP_QW = 31;

    localparam logic [30:0] L2E_Q30 = 31'h5C551D95;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    localparam logic signed [37:0] C_ONE      = 38'sd1073741824;
    localparam logic signed [37:0] C_SIX      = 38'sd6442450944;
    localparam logic signed [37:0] C_FOURTEEN = 38'sd15032385536;
    localparam logic [35:0]        C_THIRTYSIX = 36'd38654705664;

    localparam logic [2:0] ORDER_1 = 3'd1;
    localparam logic [2:0] ORDER_2 = 3'd2;
    localparam logic [2:0] ORDER_3 = 3'd3;

    typedef enum logic [1:0] {
        POLY_D1,
        POLY_D2,
        POLY_D3,
        POLY_D4
    } t_poly_sel;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [32:0] e;
    } t_exp_beat;

    typedef struct packed {
        logic        valid;
        logic [30:0] p;
    } t_rcp_beat;

    typedef struct packed {
        logic        valid;
        logic [31:0] derivative;
    } t_poly_beat;

    // floor((2^(32+l) - 1) / k), l = floor(log2 k)
    function automatic logic [31:0] recip_m(input int k);
        logic [31:0] m;
        case (k)
            1, 2, 4, 8: m = 32'hFFFFFFFF;
            3, 6, 12:   m = 32'hAAAAAAAA;
            5, 10:      m = 32'hCCCCCCCC;
            7:          m = 32'h92492492;
            9:          m = 32'hE38E38E3;
            11:         m = 32'hBA2E8BA2;
            default:    m = 32'hFFFFFFFF;
        endcase
        return m;
    endfunction

    function automatic int recip_l(input int k);
        int l;
        case (k)
            1:                    l = 0;
            2, 3:                 l = 1;
            4, 5, 6, 7:           l = 2;
            default:              l = 3;
        endcase
        return l;
    endfunction

    function automatic t_poly_sel decode_order(input logic [2:0] order);
        t_poly_sel sel;
        case (order)
            ORDER_1: sel = POLY_D1;
            ORDER_2: sel = POLY_D2;
            ORDER_3: sel = POLY_D3;
            default: sel = POLY_D4;
        endcase
        return sel;
    endfunction

endpackage

FILE: sv/lsdu_ifs.sv
`timescale 1ns / 1ps

interface lsdu_eta_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] eta;

    modport source (output valid, output eta, input ready);
    modport sink   (input valid, input eta, output ready);
endinterface

interface lsdu_drv_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] derivative;

    modport source (output valid, output derivative, input ready);
    modport sink   (input valid, input derivative, output ready);
endinterface

FILE: sv/lsdu_exp.sv
`timescale 1ns / 1ps

// exp(-|eta|) in Q1.32: range reduction, then one Horner term per 3 stages.
module lsdu_exp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [31:0]           i_eta,
    output lsdu_pkg::t_exp_beat   o_beat
);

    localparam int NW = lsdu_pkg::EXP_INT_W;
    localparam int NT = lsdu_pkg::EXP_TERMS;
    localparam int IF = lsdu_pkg::IN_FRAC;

    typedef struct packed {
        logic          neg;
        logic [NW-1:0] n;
        logic [31:0]   r;
    } t_exp_side;

    logic          r_v0, r_v1, r_v2;
    logic          r_neg0, r_neg1, r_neg2;
    logic [31:0]   r_x;
    logic [62:0]   r_y;
    logic [63:0]   r_rp;
    logic [NW-1:0] r_n2;
    logic [31:0]   n_x;
    t_exp_side     w_side0;

    assign n_x = i_eta[31] ? (~i_eta + 32'd1) : i_eta;
    assign w_side0 = '{neg: r_neg2, n: r_n2, r: r_rp[63:32]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_neg0 <= i_eta[31];
            r_y    <= {31'b0, r_x} * {32'b0, lsdu_pkg::L2E_Q30};
            r_neg1 <= r_neg0;
            r_rp   <= {32'b0, r_y[IF+29:IF-2]} * {32'b0, lsdu_pkg::LN2_Q32};
            r_n2   <= r_y[62:IF+30];
            r_neg2 <= r_neg1;
        end
    end

    // Horner pipeline: A = r*a, B = reciprocal multiply, C = correct and 1 - x
    logic        r_va [NT];
    logic        r_vb [NT];
    logic        r_vc [NT];
    t_exp_side   r_sa [NT];
    t_exp_side   r_sb [NT];
    t_exp_side   r_sc [NT];
    logic [31:0] r_hv [NT];
    logic [31:0] r_bv [NT];
    logic [63:0] r_bm [NT];
    logic [32:0] r_ca [NT];

    for (genvar j = 0; j < NT; j++) begin : g_term
        localparam int          K = NT - j;
        localparam int          L = lsdu_pkg::recip_l(K);
        localparam logic [31:0] M = lsdu_pkg::recip_m(K);

        logic [32:0] w_a;
        t_exp_side   w_s;
        logic        w_v;
        logic [64:0] w_ra;
        logic [31:0] w_q0;
        logic [31:0] w_rem;
        logic [31:0] w_q;
        logic [32:0] n_a;

        if (j == 0) begin : g_first
            assign w_a = 33'h1_0000_0000;
            assign w_s = w_side0;
            assign w_v = r_v2;
        end else begin : g_next
            assign w_a = r_ca[j-1];
            assign w_s = r_sc[j-1];
            assign w_v = r_vc[j-1];
        end

        assign w_ra  = {33'b0, w_s.r} * {32'b0, w_a};
        assign w_q0  = 32'(r_bm[j] >> (32 + L));
        assign w_rem = r_bv[j] - 32'(w_q0 * 32'(K));
        assign w_q   = (w_rem >= 32'(K)) ? (w_q0 + 32'd1) : w_q0;
        assign n_a   = 33'h1_0000_0000 - {1'b0, w_q};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[j] <= 1'b0;
                r_vb[j] <= 1'b0;
                r_vc[j] <= 1'b0;
            end else if (i_en) begin
                r_va[j] <= w_v;
                r_vb[j] <= r_va[j];
                r_vc[j] <= r_vb[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hv[j] <= w_ra[63:32];
                r_sa[j] <= w_s;
                r_bm[j] <= {32'b0, r_hv[j]} * {32'b0, M};
                r_bv[j] <= r_hv[j];
                r_sb[j] <= r_sa[j];
                r_ca[j] <= n_a;
                r_sc[j] <= r_sb[j];
            end
        end
    end

    // scale by 2^-n; shifts of 33 or more give zero
    logic        r_ev;
    logic        r_eneg;
    logic [32:0] r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (i_en) begin
            r_ev <= r_vc[NT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e    <= r_ca[NT-1] >> r_sc[NT-1].n;
            r_eneg <= r_sc[NT-1].neg;
        end
    end

    assign o_beat = '{valid: r_ev, neg: r_eneg, e: r_e};

endmodule

FILE: sv/lsdu_recip.sv
`timescale 1ns / 1ps

// p = (2^62 + d/2) / d, d = 2^32 + e; restoring division, one quotient bit per stage.
module lsdu_recip (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lsdu_pkg::t_exp_beat   i_beat,
    output lsdu_pkg::t_rcp_beat   o_beat
);

    localparam int QW = lsdu_pkg::RCP_QW;

    logic          r_v0;
    logic          r_neg0;
    logic [33:0]   r_d0;
    logic [34:0]   r_rem0;
    logic [QW-1:0] r_nl0;
    logic [33:0]   n_d;
    logic [32:0]   w_h;

    assign n_d = {1'b0, i_beat.e} + 34'h1_0000_0000;
    assign w_h = n_d[33:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0   <= n_d;
            r_neg0 <= i_beat.neg;
            r_rem0 <= {33'b0, w_h[32:31]} + 35'h0_8000_0000;
            r_nl0  <= w_h[QW-1:0];
        end
    end

    logic          r_v   [QW];
    logic          r_ng  [QW];
    logic [33:0]   r_dd  [QW];
    logic [34:0]   r_rem [QW];
    logic [QW-1:0] r_nl  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_bit
        localparam int B = QW - 1 - i;

        logic          w_v;
        logic          w_ng;
        logic [33:0]   w_d;
        logic [34:0]   w_rem;
        logic [QW-1:0] w_nl;
        logic [QW-1:0] w_q;
        logic [34:0]   w_sh;
        logic          w_ge;

        if (i == 0) begin : g_first
            assign w_v   = r_v0;
            assign w_ng  = r_neg0;
            assign w_d   = r_d0;
            assign w_rem = r_rem0;
            assign w_nl  = r_nl0;
            assign w_q   = '0;
        end else begin : g_next
            assign w_v   = r_v[i-1];
            assign w_ng  = r_ng[i-1];
            assign w_d   = r_dd[i-1];
            assign w_rem = r_rem[i-1];
            assign w_nl  = r_nl[i-1];
            assign w_q   = r_q[i-1];
        end

        assign w_sh = {w_rem[33:0], w_nl[B]};
        assign w_ge = (w_sh >= {1'b0, w_d});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ng[i]   <= w_ng;
                r_dd[i]   <= w_d;
                r_nl[i]   <= w_nl;
                r_rem[i]  <= w_ge ? (w_sh - {1'b0, w_d}) : w_sh;
                r_q[i]    <= w_q | (QW'(w_ge) << B);
            end
        end
    end

    // mirror for negative eta: p = 1 - s
    logic          r_pv;
    logic [QW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= r_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_ng[QW-1] ? (QW'(31'h4000_0000) - r_q[QW-1]) : r_q[QW-1];
        end
    end

    assign o_beat = '{valid: r_pv, p: r_p};

endmodule

FILE: sv/lsdu_poly.sv
`timescale 1ns / 1ps

// pq times the Horner polynomial of the selected order; Q1.30 products round
// half away from zero (round on magnitude, then re-apply sign).
module lsdu_poly (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [2:0]            i_order,
    input  lsdu_pkg::t_rcp_beat   i_beat,
    output lsdu_pkg::t_poly_beat  o_beat
);

    lsdu_pkg::t_poly_sel w_sel;
    assign w_sel = lsdu_pkg::decode_order(i_order);

    logic [6:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_beat.valid};
        end
    end

    // P0: pq and p*(36 - 24p) products
    logic [30:0] r0_p;
    logic [61:0] r0_pq;
    logic [66:0] r0_m1;
    logic [30:0] w_q;
    logic [35:0] w_in1;

    assign w_q   = 31'h4000_0000 - i_beat.p;
    assign w_in1 = lsdu_pkg::C_THIRTYSIX - ({1'b0, i_beat.p, 4'b0} + {2'b0, i_beat.p, 3'b0});

    // P1: round
    logic [30:0] r1_p;
    logic [28:0] r1_pq;
    logic [35:0] r1_m1;

    // P2: second inner term
    logic [30:0]        r2_p;
    logic [28:0]        r2_pq;
    logic signed [37:0] r2_in;
    logic signed [37:0] w_p2;
    logic signed [37:0] n_in;

    assign w_p2 = $signed({7'b0, r1_p});
    always_comb begin
        case (w_sel)
            lsdu_pkg::POLY_D3: n_in = (w_p2 <<< 2) + (w_p2 <<< 1) - lsdu_pkg::C_SIX;
            default:           n_in = $signed({2'b0, r1_m1}) - lsdu_pkg::C_FOURTEEN;
        endcase
    end

    // P3: p * |inner|
    logic [30:0] r3_p;
    logic [28:0] r3_pq;
    logic        r3_neg;
    logic [67:0] r3_prod;
    logic [36:0] w_mag3;

    assign w_mag3 = r2_in[37] ? 37'(-r2_in) : r2_in[36:0];

    // P4: t
    logic [28:0]        r4_pq;
    logic signed [37:0] r4_t;
    logic [67:0]        w_rnd4;
    logic signed [37:0] w_m2;
    logic signed [37:0] w_p4;
    logic signed [37:0] n_t;

    assign w_rnd4 = (r3_prod + 68'h2000_0000) >> 30;
    assign w_m2   = r3_neg ? -$signed(w_rnd4[37:0]) : $signed(w_rnd4[37:0]);
    assign w_p4   = $signed({7'b0, r3_p});
    always_comb begin
        case (w_sel)
            lsdu_pkg::POLY_D1: n_t = lsdu_pkg::C_ONE;
            lsdu_pkg::POLY_D2: n_t = lsdu_pkg::C_ONE - (w_p4 <<< 1);
            default:           n_t = lsdu_pkg::C_ONE + w_m2;
        endcase
    end

    // P5: pq * |t|
    logic        r5_neg;
    logic [65:0] r5_prod;
    logic [36:0] w_mag5;

    assign w_mag5 = r4_t[37] ? 37'(-r4_t) : r4_t[36:0];

    // P6: round, sign, saturate
    logic [31:0]        r6_res;
    logic [65:0]        w_rnd6;
    logic signed [37:0] w_res;
    logic [31:0]        n_res;

    assign w_rnd6 = (r5_prod + 66'h2000_0000) >> 30;
    assign w_res  = r5_neg ? -$signed(w_rnd6[37:0]) : $signed(w_rnd6[37:0]);
    always_comb begin
        if (w_res > 38'sd2147483647) begin
            n_res = 32'h7FFF_FFFF;
        end else if (w_res < -38'sd2147483648) begin
            n_res = 32'h8000_0000;
        end else begin
            n_res = w_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_p    <= i_beat.p;
            r0_pq   <= {31'b0, i_beat.p} * {31'b0, w_q};
            r0_m1   <= {36'b0, i_beat.p} * {31'b0, w_in1};
            r1_p    <= r0_p;
            r1_pq   <= 29'((r0_pq + 62'h2000_0000) >> 30);
            r1_m1   <= 36'((r0_m1 + 67'h2000_0000) >> 30);
            r2_p    <= r1_p;
            r2_pq   <= r1_pq;
            r2_in   <= n_in;
            r3_p    <= r2_p;
            r3_pq   <= r2_pq;
            r3_neg  <= r2_in[37];
            r3_prod <= {37'b0, r2_p} * {31'b0, w_mag3};
            r4_pq   <= r3_pq;
            r4_t    <= n_t;
            r5_neg  <= r4_t[37];
            r5_prod <= {37'b0, r4_pq} * {29'b0, w_mag5};
            r6_res  <= n_res;
        end
    end

    assign o_beat = '{valid: r_v[6], derivative: r6_res};

endmodule

FILE: sv/logistic_sigmoid_derivative_unit.sv
`timescale 1ns / 1ps

// Logistic sigmoid derivative unit. Each eta beat (signed Q8.24) yields one
// derivative beat (signed Q2.30, saturated) of order 1..4 of p = 1/(1+exp(-eta));
// the order comes from the derivative_order register at APB address 0 (reset 1;
// any value other than 1, 2 or 3 gives order four). The register must be written
// only while the unit is idle; the unit itself does not enforce this. The unit
// takes one beat per clock while the pipeline is not stalled. It holds 40 stages
// for the exponential (three Horner stages per each of the 12 Taylor terms), 33
// for the bit-serial pipelined reciprocal (one quotient bit per stage), 7 for the
// polynomial and one output register. The whole pipeline stalls only when the
// output register holds an untaken beat and the last pipeline stage is also full.
module logistic_sigmoid_derivative_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lsdu_eta_if.sink          i_eta_ch,
    lsdu_drv_if.source        o_drv_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // --- configuration register ---
    logic [2:0] r_order;
    logic       w_wr;

    assign w_wr   = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, r_order};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= lsdu_pkg::ORDER_1;
        end else if (w_wr) begin
            r_order <= pwdata[2:0];
        end
    end

    // --- datapath ---
    logic                  w_adv;
    lsdu_pkg::t_exp_beat   w_exp;
    lsdu_pkg::t_rcp_beat   w_rcp;
    lsdu_pkg::t_poly_beat  w_poly;

    lsdu_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_eta_ch.valid),
        .i_eta   (i_eta_ch.eta),
        .o_beat  (w_exp)
    );

    lsdu_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_beat  (w_exp),
        .o_beat  (w_rcp)
    );

    lsdu_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_order (r_order),
        .i_beat  (w_rcp),
        .o_beat  (w_poly)
    );

    // --- output register ---
    // pipeline moves unless a finished beat would overwrite an untaken one
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        w_out_free;

    assign w_out_free = !r_out_valid || o_drv_ch.ready;
    assign w_adv      = w_out_free || !w_poly.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_poly.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= w_poly.derivative;
        end
    end

    assign i_eta_ch.ready      = w_adv;
    assign o_drv_ch.valid      = r_out_valid;
    assign o_drv_ch.derivative = r_out_data;

    // --- checks ---
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> r_out_valid)
        else $error("pipeline stalled with empty output register");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_order == $past(pwdata[2:0])))
        else $error("derivative_order write lost");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(o_drv_ch.ready))
        else $error("output beat dropped without handshake");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

// Checks the logistic sigmoid derivative unit against an in-bench predictor.
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int FLUSH_CYCLES = 100;    // more than the pipeline depth
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int PHASE_ITEMS = 144;

    // Expected derivative beats plus the bench's copy of the order register.
    class deriv_scoreboard;
        logic [31:0] want_q[$];
        logic [2:0]  order;
        int          mismatches;
        int          checked;

        function new();
            order = lsdu_pkg::ORDER_1;
            mismatches = 0;
            checked = 0;
        endfunction

        // (a*b) >> 30 rounded half up
        function automatic logic [63:0] mul_q30_u(logic [63:0] a, logic [63:0] b);
            logic [63:0] bh, bl;
            bh = b >> 30;
            bl = b & ((64'd1 << 30) - 64'd1);
            return a * bh + ((a * bl + (64'd1 << 29)) >> 30);
        endfunction

        // Q30 product, a >= 0, rounded half away from zero
        function automatic longint mul_q30(longint a, longint b);
            logic [63:0] mb;
            longint      m;
            mb = (b < 0) ? 64'(-b) : 64'(b);
            m = longint'(mul_q30_u(64'(a), mb));
            return (b < 0) ? -m : m;
        endfunction

        function automatic logic [31:0] derive(logic [31:0] raw);
            logic [63:0] x, y, n, f, r, a, e, d, s;
            longint      p, pq, t, inner, res;
            longint      one;
            one = longint'(1) << 30;
            x = raw[31] ? ((64'd1 << 32) - 64'(raw)) : 64'(raw);
            // exp(-x): base-2 range reduction, then Taylor series by Horner
            y = x * 64'h5C551D95;
            n = y >> 54;
            f = (y >> 22) & 64'hFFFF_FFFF;
            r = (f * 64'hB172_17F8) >> 32;
            a = 64'd1 << 32;
            for (int k = 12; k >= 1; k--)
                a = (64'd1 << 32) - (((r * a) >> 32) / 64'(k));
            e = (n > 63) ? 64'd0 : (a >> n);
            d = (64'd1 << 32) + e;
            s = ((64'd1 << 62) + (d >> 1)) / d;
            p = raw[31] ? one - longint'(s) : longint'(s);
            pq = mul_q30(p, one - p);
            case (order)
                lsdu_pkg::ORDER_1: t = one;
                lsdu_pkg::ORDER_2: t = one - 2 * p;
                lsdu_pkg::ORDER_3: begin
                    inner = -6 * one + 6 * p;
                    t = one + mul_q30(p, inner);
                end
                default: begin
                    inner = 36 * one - 24 * p;
                    inner = -14 * one + mul_q30(p, inner);
                    t = one + mul_q30(p, inner);
                end
            endcase
            res = (order == lsdu_pkg::ORDER_1) ? pq : mul_q30(pq, t);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            return res[31:0];
        endfunction

        function void note_eta(logic [31:0] eta);
            want_q.push_back(derive(eta));
        endfunction

        function void check_beat(logic [31:0] got);
            logic [31:0] want;
            checked++;
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected derivative beat %h", got);
                return;
            end
            want = want_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("derivative mismatch: expected %h, got %h", want, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lsdu_eta_if eta_ch ();
    lsdu_drv_if drv_ch ();

    logistic_sigmoid_derivative_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_eta_ch(eta_ch),
        .o_drv_ch(drv_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    deriv_scoreboard sb = new();

    int  cycles = 0;
    bit  gaps_on = 1;       // sender draws idle cycles per beat
    bit  stalls_on = 1;     // receiver draws stall cycles per beat
    bit  hold_req = 0;      // receiver: one long hold-off
    int  sent = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        eta_ch.valid = 1'b0;
        eta_ch.eta = '0;
        drv_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Beat monitors, sampling pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && eta_ch.valid && eta_ch.ready)
            sb.note_eta(eta_ch.eta);
        if (i_rst_n && drv_ch.valid && drv_ch.ready)
            sb.check_beat(drv_ch.derivative);
    end

    // Receiver: random stall before each beat, plus a requested long hold-off
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = stalls_on ? $urandom_range(0, 14) : 0;
            if (hold_req) begin
                drv_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end
            if (w > 0) begin
                drv_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            drv_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(drv_ch.valid && drv_ch.ready));
        end
    end

    task automatic send_eta(logic [31:0] v);
        int g;
        g = gaps_on ? $urandom_range(0, 14) : 0;
        if (g > 0) begin
            eta_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        eta_ch.valid <= 1'b1;
        eta_ch.eta <= v;
        do @(posedge i_clk); while (!eta_ch.ready);
        sent++;
    endtask

    task automatic end_burst();
        eta_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expected beat is back, then let the pipe empty
    task automatic drain();
        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'd0)
            sb.order = data[2:0];
        @(posedge i_clk);
    endtask

    // Mostly the interesting band |eta| < 32, some full-range words
    function automatic logic [31:0] rand_eta();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom();
        else if (sel < 8)
            return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
        else
            return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    endfunction

    logic [31:0] edge_etas[20] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h8000_0001, 32'h0100_0000, 32'hFF00_0000,
        32'h0080_0000, 32'hFF80_0000, 32'h0200_0000, 32'hFE00_0000,
        32'h2000_0000, 32'hE000_0000, 32'h2C00_0000, 32'hD400_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h00B1_7218, 32'hFF4E_8DE8
    };

    logic [31:0] order_plan[8] = '{
        32'd2, 32'd3, 32'd4, 32'd0, 32'd7, 32'd5, 32'hFFFF_FFF9, 32'd1
    };

    initial begin
        @(posedge i_clk iff i_rst_n);
        @(posedge i_clk);

        // Directed: edge values of eta under every order, reset order first
        for (int o = 0; o < 5; o++) begin
            if (o > 0) apb_write(3'd0, o == 4 ? 32'd6 : 32'(o + 1));
            foreach (edge_etas[i]) send_eta(edge_etas[i]);
            end_burst();
            drain();
        end
        // Write to a non-existent register must not change the order
        apb_write(3'd4, 32'd3);

        for (int ph = 0; ph < 8; ph++) begin
            apb_write(3'd0, order_plan[ph]);
            gaps_on = (ph != 2);
            stalls_on = (ph != 2) && (ph != 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 3 && i == 20) begin
                    // back-to-back offers while the receiver holds off
                    gaps_on = 0;
                    hold_req = 1;
                end
                if (ph == 3 && i == 120) gaps_on = 1;
                if (ph == 6 && i == 80) begin
                    end_burst();
                    while (sb.want_q.size() != 0) @(posedge i_clk);
                end
                send_eta(rand_eta());
            end
            end_burst();
            drain();
        end

        $display("sent %0d eta beats, checked %0d derivative beats over orders 0..7",
                 sent, sb.checked);
        $display("mismatches %0d, left over %0d", sb.mismatches, sb.want_q.size());
        if (sb.mismatches == 0 && sb.want_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
